// ===== hdl/cartesian_to_polar_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cartesian to polar converter
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_POLAR_TOP_MACROS_SVH
`define CARTESIAN_TO_POLAR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C2P_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define C2P_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/c2p_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartesian to polar package
// Widths, item types and the elaboration-time arctangent constants.
// ----------------------------------------------------------------------------
package c2p_pkg;

  localparam int CW     = 16;          // coordinate width
  localparam int AF     = 13;          // angle fraction bits
  localparam int AW     = AF + 2;      // angle width, signed Q2.AF
  localparam int RW     = CW;          // radius width
  localparam int SW     = 2 * CW;      // width of x*x + y*y
  localparam int QB     = 62;          // fraction bits of the angle accumulator
  localparam int QW     = 64;          // width of the angle accumulator
  localparam int GB     = 60;          // fraction bits of the rotation datapath
  localparam int XW     = CW + 2 + GB; // width of the rotation datapath
  localparam int N_ITER = 56;          // rotation stages
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic neg;     // sign of the final angle
  } flags_t;

  typedef struct packed {
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    flags_t        fl;
  } item_t;

  // Unsigned long division by shift and subtract.
  function automatic logic [QW-1:0] c2p_udiv(input logic [QW-1:0] n, input logic [QW-1:0] d);
    logic [QW:0]   r;
    logic [QW-1:0] q;
    r = '0;
    q = '0;
    for (int i = QW - 1; i >= 0; i--) begin
      r = {r[QW-1:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // floor(n * 2^QB / d) for n < d.
  function automatic logic [QW-1:0] c2p_div_q(input logic [QW-1:0] n, input logic [QW-1:0] d);
    logic [QW-1:0] r;
    logic [QW-1:0] q;
    r = n;
    q = '0;
    for (int i = 0; i < QB; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r    = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // floor(a * b / 2^QB).
  function automatic logic [QW-1:0] c2p_mul_q(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [2*QW-1:0] p;
    p = {{QW{1'b0}}, a} * {{QW{1'b0}}, b};
    return p[QB+QW-1:QB];
  endfunction

  // atan(n/d) in Q.QB by its power series, for n/d at most one half.
  function automatic logic [QW-1:0] c2p_atan_series(input logic [QW-1:0] n,
                                                    input logic [QW-1:0] d);
    logic [QW-1:0] u;
    logic [QW-1:0] u2;
    logic [QW-1:0] p;
    logic [QW-1:0] t;
    logic [QW-1:0] acc;
    acc = '0;
    if (n != '0) begin
      u  = c2p_div_q(n, d);
      u2 = c2p_mul_q(u, u);
      p  = u;
      for (int k = 0; k < QW; k++) begin
        if (p != '0) begin
          t = c2p_udiv(p, QW'(2 * k + 1));
          if (k % 2 == 1) begin
            acc = acc - t;
          end else begin
            acc = acc + t;
          end
          p = c2p_mul_q(p, u2);
        end
      end
    end
    return acc;
  endfunction

  function automatic logic [QW-1:0] c2p_quarter_pi();
    return c2p_atan_series(QW'(1), QW'(2)) + c2p_atan_series(QW'(1), QW'(3));
  endfunction

  // atan(2^-i) in Q.QB.
  function automatic logic [QW-1:0] c2p_atan_pow2(input int i);
    logic [QW-1:0] res;
    if (i == 0) begin
      res = c2p_quarter_pi();
    end else begin
      res = c2p_atan_series(QW'(1), QW'(1) << i);
    end
    return res;
  endfunction

  localparam logic [QW-1:0] HALF_PI_Q     = c2p_quarter_pi() << 1;
  localparam logic [QW-1:0] ANG_HALF_LSB  = QW'(1) << (QB - 1 - AF);
  localparam logic [QW-1:0] HALF_PI_RND_Q = (HALF_PI_Q + ANG_HALF_LSB) >> (QB - AF);
  localparam logic [AF:0]   ANGLE_HALF_PI = HALF_PI_RND_Q[AF:0];

endpackage

// ===== hdl/c2p_if.sv =====
// ----------------------------------------------------------------------------
// Cartesian to polar channel interfaces
// Valid/ready channels for points in and polar results out.
// ----------------------------------------------------------------------------
interface c2p_in_if import c2p_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] x_coord;
  logic signed [CW-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2p_out_if import c2p_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic        [RW-1:0] radius;
  logic signed [AW-1:0] angle;

  modport source (output valid, output radius, output angle, input ready);
  modport sink   (input valid, input radius, input angle, output ready);
endinterface

// ===== hdl/c2p_front.sv =====
// ----------------------------------------------------------------------------
// Cartesian to polar front end
// Accepts points, takes magnitudes and classifies the special cases.
// ----------------------------------------------------------------------------
module c2p_front import c2p_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  c2p_in_if.sink  in_ch,
  output item_t   fr_item,
  output logic    fr_vld,
  input  logic    fr_rdy
);

  logic          fr_vld_r;
  item_t         fr_item_r;
  item_t         item_nxt;
  logic          accept;
  logic [CW-1:0] xu;
  logic [CW-1:0] yu;

  assign in_ch.ready = !fr_vld_r || fr_rdy;
  assign accept      = in_ch.valid && in_ch.ready;

  assign xu = in_ch.x_coord;
  assign yu = in_ch.y_coord;

  always_comb begin
    // The most negative coordinate maps onto its exact magnitude as unsigned.
    item_nxt.ax        = xu[CW-1] ? (~xu + 1'b1) : xu;
    item_nxt.ay        = yu[CW-1] ? (~yu + 1'b1) : yu;
    item_nxt.fl.x_zero = (xu == '0);
    item_nxt.fl.y_zero = (yu == '0);
    // On the vertical axis the sign follows y; elsewhere a point left of the
    // axis folds through the origin.
    if (xu == '0) begin
      item_nxt.fl.neg = yu[CW-1];
    end else begin
      item_nxt.fl.neg = (yu != '0) && (xu[CW-1] ^ yu[CW-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else if (accept) begin
      fr_vld_r <= 1'b1;
    end else if (fr_rdy) begin
      fr_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r <= item_nxt;
    end
  end

  assign fr_item = fr_item_r;
  assign fr_vld  = fr_vld_r;

endmodule

// ===== hdl/c2p_queue.sv =====
// ----------------------------------------------------------------------------
// Cartesian to polar item queue
// Short FIFO between the front end and the rotation pipeline.
// ----------------------------------------------------------------------------
module c2p_queue import c2p_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  item_t push_item,
  input  logic  push_vld,
  output logic  push_rdy,
  output item_t pop_item,
  output logic  pop_vld,
  input  logic  pop
);

  `include "cartesian_to_polar_top_macros.svh"

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;

  assign push_rdy = (cnt_r != QCNT_W'(QDEPTH));
  assign push     = push_vld && push_rdy;
  assign pop_vld  = (cnt_r != '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `C2P_ASSERT_NOW(a_empty_ptrs, cnt_r == '0, wr_ptr_r == rd_ptr_r, "empty queue with unequal pointers")
  `C2P_ASSERT_NEXT(a_cnt_inc, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "queue count did not rise")

endmodule

// ===== hdl/c2p_back.sv =====
// ----------------------------------------------------------------------------
// Cartesian to polar back end
// Pipelined vectoring rotation for the angle, digit-by-digit square root for
// the radius, rounding and the output register.
// ----------------------------------------------------------------------------
module c2p_back import c2p_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  item_t      q_item,
  input  logic       q_vld,
  output logic       q_pop,
  c2p_out_if.source  out_ch
);

  `include "cartesian_to_polar_top_macros.svh"

  logic                 adv;
  logic [N_ITER:0]      vld_r;
  flags_t               fl_r  [N_ITER+1];
  logic signed [XW-1:0] cx_r  [N_ITER+1];
  logic signed [XW-1:0] cy_r  [N_ITER+1];
  logic signed [QW-1:0] cz_r  [N_ITER+1];
  logic [CW-1:0]        ax0_r;
  logic [CW-1:0]        ay0_r;
  logic [SW-1:0]        sqx_r;
  logic [SW-1:0]        sqy_r;
  logic [SW-1:0]        s_r    [2:N_ITER];
  logic [RW+1:0]        rem_r  [2:N_ITER];
  logic [RW-1:0]        root_r [2:N_ITER];

  logic                 out_vld_r;
  logic [RW-1:0]        out_radius_r;
  logic [AW-1:0]        out_angle_r;
  logic [RW-1:0]        rad_nxt;
  logic [AW-1:0]        ang_nxt;
  logic signed [QW-1:0] theta_rnd;
  logic [AF:0]          ang_mag;
  logic [AW-1:0]        mag_ext;
  logic                 rnd_up;
  flags_t               fl_last;

  // The whole pipeline moves whenever the output register can take an item.
  assign adv   = !out_vld_r || out_ch.ready;
  assign q_pop = adv && q_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[N_ITER-1:0], q_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0] <= {2'b00, q_item.ax, {GB{1'b0}}};
      cy_r[0] <= {2'b00, q_item.ay, {GB{1'b0}}};
      cz_r[0] <= '0;
      fl_r[0] <= q_item.fl;
      ax0_r   <= q_item.ax;
      ay0_r   <= q_item.ay;
    end
  end

  // Rotation stages: each one drives y toward zero and accumulates atan(2^-i).
  for (genvar k = 1; k <= N_ITER; k++) begin : g_rot
    localparam int SH = k - 1;
    localparam logic signed [QW-1:0] ATAN_K = c2p_atan_pow2(SH);
    logic y_neg;

    assign y_neg = cy_r[k-1][XW-1];

    always_ff @(posedge clk) begin
      if (adv) begin
        if (y_neg) begin
          cx_r[k] <= cx_r[k-1] - (cy_r[k-1] >>> SH);
          cy_r[k] <= cy_r[k-1] + (cx_r[k-1] >>> SH);
          cz_r[k] <= cz_r[k-1] - ATAN_K;
        end else begin
          cx_r[k] <= cx_r[k-1] + (cy_r[k-1] >>> SH);
          cy_r[k] <= cy_r[k-1] - (cx_r[k-1] >>> SH);
          cz_r[k] <= cz_r[k-1] + ATAN_K;
        end
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r <= SW'(ax0_r) * SW'(ax0_r);
      sqy_r <= SW'(ay0_r) * SW'(ay0_r);
    end
  end

  // Radius stages: the sum of squares, then one root bit per stage, then hold stages that carry the result.
  for (genvar k = 2; k <= N_ITER; k++) begin : g_rad
    if (k == 2) begin : g_sum
      always_ff @(posedge clk) begin
        if (adv) begin
          s_r[k]    <= sqx_r + sqy_r;
          rem_r[k]  <= '0;
          root_r[k] <= '0;
        end
      end
    end else if (k <= RW + 2) begin : g_step
      localparam int J = RW - 1 - (k - 3);
      logic [RW+1:0] rem_t;
      logic [RW+1:0] trial;
      logic          fits;

      assign rem_t = {rem_r[k-1][RW-1:0], s_r[k-1][2*J+1 -: 2]};
      assign trial = {root_r[k-1], 2'b01};
      assign fits  = (rem_t >= trial);

      always_ff @(posedge clk) begin
        if (adv) begin
          s_r[k]    <= s_r[k-1];
          rem_r[k]  <= fits ? (rem_t - trial) : rem_t;
          root_r[k] <= {root_r[k-1][RW-2:0], fits};
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (adv) begin
          s_r[k]    <= s_r[k-1];
          rem_r[k]  <= rem_r[k-1];
          root_r[k] <= root_r[k-1];
        end
      end
    end
  end

  // Round to nearest: a remainder above the root means the sum is past r*r + r.
  assign rnd_up  = (rem_r[N_ITER] > {2'b00, root_r[N_ITER]});
  assign rad_nxt = root_r[N_ITER] + {{(RW-1){1'b0}}, rnd_up};

  assign fl_last   = fl_r[N_ITER];
  assign theta_rnd = cz_r[N_ITER] + $signed(ANG_HALF_LSB);

  always_comb begin
    priority if (fl_last.x_zero && fl_last.y_zero) begin
      ang_mag = '0;
    end else if (fl_last.x_zero) begin
      ang_mag = ANGLE_HALF_PI;
    end else if (fl_last.y_zero) begin
      ang_mag = '0;
    end else begin
      ang_mag = theta_rnd[QB:QB-AF];
    end
  end

  assign mag_ext = {1'b0, ang_mag};
  assign ang_nxt = fl_last.neg ? (~mag_ext + 1'b1) : mag_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[N_ITER];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_radius_r <= rad_nxt;
      out_angle_r  <= ang_nxt;
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.radius = out_radius_r;
  assign out_ch.angle  = out_angle_r;

  `C2P_ASSERT_NEXT(a_stall_hold, !adv, vld_r == $past(vld_r), "pipeline moved while stalled")
  `C2P_ASSERT_NEXT(a_pop_enters, q_pop, vld_r[0], "popped item did not enter the pipeline")
  `C2P_ASSERT_NEXT(a_origin, adv && vld_r[N_ITER] && fl_last.x_zero && fl_last.y_zero, out_radius_r == '0 && out_angle_r == '0, "origin gave a nonzero result")

endmodule

// ===== hdl/cartesian_to_polar_top.sv =====
// ----------------------------------------------------------------------------
// Cartesian to polar converter
// Point (x, y) in, rounded radius and single-argument arctangent out.
// ----------------------------------------------------------------------------
// The block takes one point per clock and returns one result per point, in
// order. The radius is sqrt(x*x + y*y) rounded to the nearest integer; the
// angle is atan(y/x) in signed Q2.13 radians, so a point left of the vertical
// axis gives the angle of its mirror through the origin, and on that axis the
// angle is plus or minus pi/2 (zero at the origin). Throughput is one item per
// cycle while the output side is ready. A result passes the input register,
// the queue slot, the pipeline's entry register, the 56-stage vectoring
// rotation pipeline and the output register. A four-item queue separates the
// input side from the pipeline, so the input keeps accepting after the output
// stalls until the queue fills; the pipeline itself freezes as a whole while
// a finished result waits.
module cartesian_to_polar_top import c2p_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  c2p_in_if.sink    in_ch,
  c2p_out_if.source out_ch
);

  item_t fr_item;
  logic  fr_vld;
  logic  fr_rdy;
  item_t q_item;
  logic  q_vld;
  logic  q_pop;

  c2p_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .fr_item (fr_item),
    .fr_vld  (fr_vld),
    .fr_rdy  (fr_rdy)
  );

  c2p_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_item (fr_item),
    .push_vld  (fr_vld),
    .push_rdy  (fr_rdy),
    .pop_item  (q_item),
    .pop_vld   (q_vld),
    .pop       (q_pop)
  );

  c2p_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_item (q_item),
    .q_vld  (q_vld),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
